### hdl/svd_pkg.sv
// Shared types and codes for the servo status packet deframer.
// No dependencies; every other file imports this package.
package svd_pkg;

    // Input action codes
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_BYTE    = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    // Status codes carried in a status word
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_STALE   = 3'd1;
    localparam logic [2:0] ST_CHKBAD  = 3'd2;
    localparam logic [2:0] ST_BADLEN  = 3'd3;
    localparam logic [2:0] ST_IDMIS   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT = 3'd5;

    // Result kinds
    localparam logic KIND_PARAM  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Configuration register indexes
    localparam logic CFG_BCAST_ID     = 1'b0;
    localparam logic CFG_MAX_ATTEMPTS = 1'b1;

    localparam logic [7:0] BCAST_ID_RST     = 8'd254;
    localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd4;
    localparam logic [7:0] HDR_BYTE         = 8'hff;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HUNT  = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_ERR   = 3'd4,
        PH_PARAM = 3'd5,
        PH_CHK   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
        logic [7:0] want_id;
    } t_item;

    typedef struct packed {
        logic [7:0] bcast_id;
        logic [3:0] max_attempts;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [7:0] param_index;
        logic [2:0] status;
        logic [7:0] servo_error;
        logic [7:0] responder_id;
        logic       done_res;
    } t_res;

    // Result buffer occupancy seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_rbuf_stat;

endpackage

### hdl/svd_in_if.sv
// Input channel: valid/ready handshake with action, byte and expected id.
// Depends on svd_pkg.
interface svd_in_if import svd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [7:0] want_id;

    modport source (output valid, output action, output rx_byte, output want_id,
                    input ready);
    modport sink (input valid, input action, input rx_byte, input want_id,
                  output ready);
endinterface

### hdl/svd_out_if.sv
// Output channel: valid/ready handshake carrying one result word.
// Depends on svd_pkg.
interface svd_out_if import svd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data;
    logic [7:0] param_index;
    logic [2:0] status;
    logic [7:0] servo_error;
    logic [7:0] responder_id;
    logic       done_res;

    modport source (output valid, output kind, output data, output param_index,
                    output status, output servo_error, output responder_id,
                    output done_res, input ready);
    modport sink (input valid, input kind, input data, input param_index,
                  input status, input servo_error, input responder_id,
                  input done_res, output ready);
endinterface

### hdl/svd_core.sv
// Packet parser: header hunt, field capture, checksum and retry logic.
// Depends on svd_pkg; each accepted word updates the state registers.
module svd_core import svd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fire,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_res_valid,
    output t_res  o_res,
    output logic  o_busy
);

    t_phase     r_phase, n_phase;
    logic       r_prev_ff, n_prev_ff;
    logic [7:0] r_wanted, n_wanted;
    logic [3:0] r_att, n_att;
    logic [7:0] r_pid, n_pid;
    logic [7:0] r_plen, n_plen;
    logic [7:0] r_err, n_err;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_pseen, n_pseen;

    logic       byte_ff;
    logic       sum_ok;
    logic       id_bad;
    logic [3:0] att_dec;
    logic [8:0] pseen_end;

    assign byte_ff   = (i_item.rx_byte == HDR_BYTE);
    assign sum_ok    = (i_item.rx_byte == ~r_sum);
    assign id_bad    = (r_wanted != i_cfg.bcast_id) && (r_pid != r_wanted);
    assign att_dec   = (r_att != 4'd0) ? r_att - 4'd1 : 4'd0;
    assign pseen_end = {1'b0, r_pseen} + 9'd3;
    assign o_busy    = (r_phase != PH_IDLE);

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_prev_ff = r_prev_ff;
        n_wanted  = r_wanted;
        n_att     = r_att;
        n_pid     = r_pid;
        n_plen    = r_plen;
        n_err     = r_err;
        n_sum     = r_sum;
        n_pseen   = r_pseen;
        if (i_fire) begin
            case (i_item.action)
                ACT_START: begin
                    n_wanted = i_item.want_id;
                    if (i_item.want_id == i_cfg.bcast_id) begin
                        n_att = 4'd1;
                    end else if (i_cfg.max_attempts == 4'd0) begin
                        n_att = 4'd1;
                    end else begin
                        n_att = i_cfg.max_attempts;
                    end
                    n_phase   = PH_HUNT;
                    n_prev_ff = 1'b0;
                    n_pid     = 8'd0;
                    n_plen    = 8'd0;
                    n_err     = 8'd0;
                    n_sum     = 8'd0;
                    n_pseen   = 8'd0;
                end
                ACT_TIMEOUT: begin
                    if (r_phase != PH_IDLE) begin
                        n_phase   = PH_IDLE;
                        n_prev_ff = 1'b0;
                    end
                end
                ACT_BYTE: begin
                    case (r_phase)
                        PH_IDLE: ;
                        PH_HUNT: begin
                            if (byte_ff && r_prev_ff) begin
                                n_phase   = PH_ID;
                                n_prev_ff = 1'b0;
                            end else begin
                                n_prev_ff = byte_ff;
                            end
                        end
                        PH_ID: begin
                            n_pid   = i_item.rx_byte;
                            n_sum   = i_item.rx_byte;
                            n_phase = PH_LEN;
                        end
                        PH_LEN: begin
                            n_plen  = i_item.rx_byte;
                            n_sum   = r_sum + i_item.rx_byte;
                            n_phase = PH_ERR;
                        end
                        PH_ERR: begin
                            n_err   = i_item.rx_byte;
                            n_sum   = r_sum + i_item.rx_byte;
                            n_pseen = 8'd0;
                            if (r_plen < 8'd2) begin
                                n_phase = PH_IDLE;
                            end else if (r_plen == 8'd2) begin
                                n_phase = PH_CHK;
                            end else begin
                                n_phase = PH_PARAM;
                            end
                        end
                        PH_PARAM: begin
                            n_sum   = r_sum + i_item.rx_byte;
                            n_pseen = r_pseen + 8'd1;
                            // last parameter once seen + 3 reaches the length
                            if (pseen_end >= {1'b0, r_plen}) begin
                                n_phase = PH_CHK;
                            end
                        end
                        PH_CHK: begin
                            if (!sum_ok) begin
                                n_phase = PH_IDLE;
                            end else if (id_bad) begin
                                n_att = att_dec;
                                if (att_dec != 4'd0) begin
                                    n_phase   = PH_HUNT;
                                    n_prev_ff = 1'b0;
                                end else begin
                                    n_phase = PH_IDLE;
                                end
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Result word
    always_comb begin
        o_res_valid        = 1'b0;
        o_res.kind         = KIND_STATUS;
        o_res.data         = 8'd0;
        o_res.param_index  = 8'd0;
        o_res.status       = ST_OK;
        o_res.servo_error  = r_err;
        o_res.responder_id = r_pid;
        o_res.done_res     = 1'b1;
        if (i_fire) begin
            case (i_item.action)
                ACT_TIMEOUT: begin
                    if (r_phase != PH_IDLE) begin
                        o_res_valid        = 1'b1;
                        o_res.status       = ST_TIMEOUT;
                        o_res.servo_error  = 8'd0;
                        o_res.responder_id = 8'd0;
                    end
                end
                ACT_BYTE: begin
                    case (r_phase)
                        PH_ERR: begin
                            if (r_plen < 8'd2) begin
                                o_res_valid       = 1'b1;
                                o_res.status      = ST_BADLEN;
                                o_res.servo_error = i_item.rx_byte;
                            end
                        end
                        PH_PARAM: begin
                            o_res_valid       = 1'b1;
                            o_res.kind        = KIND_PARAM;
                            o_res.data        = i_item.rx_byte;
                            o_res.param_index = r_pseen;
                            o_res.done_res    = 1'b0;
                        end
                        PH_CHK: begin
                            o_res_valid = 1'b1;
                            if (!sum_ok) begin
                                o_res.status = ST_CHKBAD;
                            end else if (id_bad) begin
                                if (att_dec != 4'd0) begin
                                    o_res.status   = ST_STALE;
                                    o_res.done_res = 1'b0;
                                end else begin
                                    o_res.status = ST_IDMIS;
                                end
                            end else begin
                                o_res.status = ST_OK;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_prev_ff <= 1'b0;
            r_wanted  <= 8'd0;
            r_att     <= 4'd0;
            r_pid     <= 8'd0;
            r_plen    <= 8'd0;
            r_err     <= 8'd0;
            r_sum     <= 8'd0;
            r_pseen   <= 8'd0;
        end else begin
            r_phase   <= n_phase;
            r_prev_ff <= n_prev_ff;
            r_wanted  <= n_wanted;
            r_att     <= n_att;
            r_pid     <= n_pid;
            r_plen    <= n_plen;
            r_err     <= n_err;
            r_sum     <= n_sum;
            r_pseen   <= n_pseen;
        end
    end

endmodule

### hdl/svd_rbuf.sv
// Two-entry result buffer between the parser and the output channel.
// Depends on svd_pkg; the head entry drives the output registers directly.
module svd_rbuf import svd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_res       i_res,
    input  logic       i_pop,
    output logic       o_valid,
    output t_res       o_res,
    output t_rbuf_stat o_stat
);

    t_res       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       do_pop;

    assign do_pop       = i_pop && (r_cnt != 2'd0);
    assign o_valid      = (r_cnt != 2'd0);
    assign o_res        = r_q[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

### hdl/servo_status_packet_deframer.sv
// Top level of the servo status packet deframer.
// Depends on svd_pkg, svd_in_if, svd_out_if, svd_core and svd_rbuf.
// Usage:
//   i_in carries one word per handshake: a start (with the expected id),
//   a received bus byte, or a timeout event. o_out carries result words:
//   parameter bytes as they arrive, and one status word per packet at the
//   checksum byte, plus a status word on timeout or bad length.
//   The user must write configuration (broadcast id, max attempts) via
//   i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle; not checked.
// Timing:
//   One input word per cycle while i_in.ready is high. A result is formed
//   combinationally from the parser state and the accepted input word and
//   is written into the result buffer, whose head entry drives o_out.
//   A two-entry result buffer decouples the sides: i_in.ready stays high
//   while at most one result is pending, so input keeps flowing while a
//   result waits. When the receiver stalls and the buffer fills,
//   i_in.ready drops until o_out takes a word.
// Reset:
//   Synchronous, active low. Parser returns to idle, buffer empties,
//   registers return to broadcast id 254 and max attempts 4.
module servo_status_packet_deframer import svd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    svd_in_if.sink     i_in,
    svd_out_if.source  o_out
);

    t_cfg       r_cfg;
    t_item      in_item;
    t_res       core_res;
    t_res       head_res;
    t_rbuf_stat rbuf_stat;
    logic       in_fire;
    logic       core_res_valid;
    logic       core_busy;
    logic       head_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bcast_id     <= BCAST_ID_RST;
            r_cfg.max_attempts <= MAX_ATTEMPTS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BCAST_ID:     r_cfg.bcast_id     <= i_cfg_data;
                CFG_MAX_ATTEMPTS: r_cfg.max_attempts <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Input handshake
    assign i_in.ready      = !rbuf_stat.full;
    assign in_fire         = i_in.valid && i_in.ready;
    assign in_item.action  = i_in.action;
    assign in_item.rx_byte = i_in.rx_byte;
    assign in_item.want_id = i_in.want_id;

    svd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_item      (in_item),
        .i_cfg       (r_cfg),
        .o_res_valid (core_res_valid),
        .o_res       (core_res),
        .o_busy      (core_busy)
    );

    svd_rbuf u_rbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_res_valid),
        .i_res   (core_res),
        .i_pop   (o_out.ready),
        .o_valid (head_valid),
        .o_res   (head_res),
        .o_stat  (rbuf_stat)
    );

    // Output channel
    assign o_out.valid        = head_valid;
    assign o_out.kind         = head_res.kind;
    assign o_out.data         = head_res.data;
    assign o_out.param_index  = head_res.param_index;
    assign o_out.status       = head_res.status;
    assign o_out.servo_error  = head_res.servo_error;
    assign o_out.responder_id = head_res.responder_id;
    assign o_out.done_res     = head_res.done_res;

    // A full buffer must hold off the input side
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rbuf_stat.full |-> !i_in.ready)
        else $error("input ready while result buffer full");

    // Timeout during a reception always yields a result word
    a_timeout_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in.action == ACT_TIMEOUT) && core_busy) |=> o_out.valid)
        else $error("timeout while busy produced no result");

    // Parameter words never end a transaction
    a_param_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == KIND_PARAM))
            |-> (!o_out.done_res && (o_out.status == ST_OK)))
        else $error("parameter word marked as final or with status");

    // An empty buffer never presents a valid output word
    a_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rbuf_stat.empty |-> !o_out.valid)
        else $error("output valid from empty buffer");

endmodule
